[src/adpg_pkg.sv]
// ----------------------------------------------------------------------------
// Disc pixel generator package
// Shared register indexes, region codes and fixed widths.
// ----------------------------------------------------------------------------
package adpg_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 4;

    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int COLOR_W  = 16;
    localparam int CFGQ_W   = 16;
    localparam int DIM_W    = 13;
    localparam int EDGE_W   = 12;
    localparam int HI_W     = 18;
    localparam int LO_W     = 19;
    localparam int WEIGHT_W = 17;
    localparam int DVS_W    = 13;

    typedef enum logic [2:0] {
        REG_IMAGE_ROWS  = 3'd0,
        REG_IMAGE_COLS  = 3'd1,
        REG_CENTER_COL  = 3'd2,
        REG_CENTER_ROW  = 3'd3,
        REG_DISC_RADIUS = 3'd4,
        REG_INNER_COLOR = 3'd5,
        REG_OUTER_COLOR = 3'd6,
        REG_EDGE_WIDTH  = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        REGION_INNER = 2'd0,
        REGION_EDGE  = 2'd1,
        REGION_OUTER = 2'd2
    } region_t;

    // Blend control that rides along the divider.
    typedef struct packed {
        region_t region;
        logic    zero_w;
        logic    full_w;
    } blend_ctl_t;

endpackage

[src/adpg_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per register stage, with a sideband that travels alongside.
// ----------------------------------------------------------------------------
module adpg_sqrt
    import adpg_pkg::*;
#(
    parameter int SQW = 25,
    parameter int SBW = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [2*SQW-1:0]     in_x,
    input  logic [SBW-1:0]       in_sb,
    output logic                 out_vld,
    output logic [SQW-1:0]       out_root,
    output logic [SBW-1:0]       out_sb
);

    localparam int XW = 2 * SQW;
    localparam int RW = SQW + 2;

    logic           vld_reg  [SQW];
    logic [XW-1:0]  x_reg    [SQW];
    logic [RW-1:0]  rem_reg  [SQW];
    logic [SQW-1:0] root_reg [SQW];
    logic [SBW-1:0] sb_reg   [SQW];

    genvar k;
    generate
        for (k = 0; k < SQW; k++)
        begin : g_stage
            logic           vld_in;
            logic [XW-1:0]  x_in;
            logic [RW-1:0]  rem_in;
            logic [SQW-1:0] root_in;
            logic [SBW-1:0] sb_in;
            logic [RW-1:0]  cat;
            logic [RW-1:0]  trial;
            logic           ge;

            if (k == 0)
            begin : g_first
                assign vld_in  = in_vld;
                assign x_in    = in_x;
                assign rem_in  = '0;
                assign root_in = '0;
                assign sb_in   = in_sb;
            end
            else
            begin : g_next
                assign vld_in  = vld_reg[k-1];
                assign x_in    = x_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign sb_in   = sb_reg[k-1];
            end

            assign cat   = {rem_in[RW-3:0], x_in[XW-1 -: 2]};
            assign trial = {root_in, 2'b01};
            assign ge    = (cat >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k]    <= {x_in[XW-3:0], 2'b00};
                    rem_reg[k]  <= ge ? (cat - trial) : cat;
                    root_reg[k] <= {root_in[SQW-2:0], ge};
                    sb_reg[k]   <= sb_in;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[SQW-1];
    assign out_root = root_reg[SQW-1];
    assign out_sb   = sb_reg[SQW-1];

endmodule

[src/adpg_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; the user must keep the dividend's upper
// part below the divisor on entry (not enforced here) so the quotient fits in QB bits.
// ----------------------------------------------------------------------------
module adpg_div
    import adpg_pkg::*;
#(
    parameter int QB  = 16,
    parameter int DVW = 13
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [DVW+QB-1:0]  in_num,
    input  logic [DVW-1:0]     dvs,
    input  blend_ctl_t         in_ctl,
    output logic               out_vld,
    output logic [QB-1:0]      out_quot,
    output blend_ctl_t         out_ctl
);

    logic           vld_reg  [QB];
    logic [DVW-1:0] rem_reg  [QB];
    logic [QB-1:0]  n_reg    [QB];
    logic [QB-1:0]  quot_reg [QB];
    blend_ctl_t     ctl_reg  [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_stage
            logic           vld_in;
            logic [DVW-1:0] rem_in;
            logic [QB-1:0]  n_in;
            logic [QB-1:0]  quot_in;
            blend_ctl_t     ctl_in;
            logic [DVW:0]   cat;
            logic [DVW:0]   diff;
            logic           ge;

            if (k == 0)
            begin : g_first
                assign vld_in  = in_vld;
                assign rem_in  = in_num[DVW+QB-1:QB];
                assign n_in    = in_num[QB-1:0];
                assign quot_in = '0;
                assign ctl_in  = in_ctl;
            end
            else
            begin : g_next
                assign vld_in  = vld_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign n_in    = n_reg[k-1];
                assign quot_in = quot_reg[k-1];
                assign ctl_in  = ctl_reg[k-1];
            end

            assign cat  = {rem_in, n_in[QB-1]};
            assign ge   = (cat >= {1'b0, dvs});
            assign diff = cat - {1'b0, dvs};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? diff[DVW-1:0] : cat[DVW-1:0];
                    n_reg[k]    <= {n_in[QB-2:0], 1'b0};
                    quot_reg[k] <= {quot_in[QB-2:0], ge};
                    ctl_reg[k]  <= ctl_in;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[QB-1];
    assign out_quot = quot_reg[QB-1];
    assign out_ctl  = ctl_reg[QB-1];

endmodule

[src/antialiased_disc_pixel_generator_unit.sv]
// Path from input request to result: coordinate differences, squares, squared
// distance, square root pipeline, blend numerator, divider pipeline, weights, output.
// Throughput: one pixel per clock; the whole pipeline holds while a result
// waits at the output.
// Reset: rst_n clears all valid bits and loads the default configuration.
// ----------------------------------------------------------------------------
// Antialiased disc pixel generator
// Renders one pixel of a disc test pattern with a linearly blended edge.
// ----------------------------------------------------------------------------
module antialiased_disc_pixel_generator_unit
    import adpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [APB_AW-1:0]                   paddr,
    input  logic [APB_DW-1:0]                   pwdata,
    output logic [APB_DW-1:0]                   prdata,
    output logic                                pready,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: pixel_col, pixel_row, zero fill
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: pixel_value
    output logic [COLOR_W-1:0]                  m_tdata,
    // m_tuser: region[1:0], disc_fits
    output logic [2:0]                          m_tuser
);

    localparam int PW   = COORD_BITS + FRAC_BITS;
    localparam int DW   = (PW > CFGQ_W) ? PW : CFGQ_W;
    localparam int D2W  = 2 * DW + 1;
    localparam int SQW  = (D2W + 16 + 1) / 2;
    localparam int XW   = 2 * SQW;
    localparam int CW   = (D2W + 2 > 2 * HI_W) ? D2W + 2 : 2 * HI_W;
    localparam int FW   = ((SQW + 1 > LO_W + 8) ? SQW + 1 : LO_W + 8) + 1;
    localparam int NW   = FW + 10;
    localparam int QB   = 16;
    localparam int NUMW = DVS_W + QB;
    localparam int FITW = DIM_W + FRAC_BITS + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   image_rows_reg;
    logic [DIM_W-1:0]   image_cols_reg;
    logic [CFGQ_W-1:0]  center_col_reg;
    logic [CFGQ_W-1:0]  center_row_reg;
    logic [CFGQ_W-1:0]  disc_radius_reg;
    logic [COLOR_W-1:0] inner_color_reg;
    logic [COLOR_W-1:0] outer_color_reg;
    logic [EDGE_W-1:0]  edge_width_reg;
    logic               wr_en;
    reg_index_t         wr_idx;
    reg_index_t         rd_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_index_t'(paddr[4:2]);
    assign rd_idx = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg  <= DIM_W'(480);
            image_cols_reg  <= DIM_W'(640);
            center_col_reg  <= CFGQ_W'(5120);
            center_row_reg  <= CFGQ_W'(3840);
            disc_radius_reg <= CFGQ_W'(1600);
            inner_color_reg <= '0;
            outer_color_reg <= '1;
            edge_width_reg  <= EDGE_W'(16);
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_IMAGE_ROWS:  image_rows_reg  <= pwdata[DIM_W-1:0];
                REG_IMAGE_COLS:  image_cols_reg  <= pwdata[DIM_W-1:0];
                REG_CENTER_COL:  center_col_reg  <= pwdata[CFGQ_W-1:0];
                REG_CENTER_ROW:  center_row_reg  <= pwdata[CFGQ_W-1:0];
                REG_DISC_RADIUS: disc_radius_reg <= pwdata[CFGQ_W-1:0];
                REG_INNER_COLOR: inner_color_reg <= pwdata[COLOR_W-1:0];
                REG_OUTER_COLOR: outer_color_reg <= pwdata[COLOR_W-1:0];
                REG_EDGE_WIDTH:  edge_width_reg  <= pwdata[EDGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (rd_idx)
            REG_IMAGE_ROWS:  prdata = APB_DW'(image_rows_reg);
            REG_IMAGE_COLS:  prdata = APB_DW'(image_cols_reg);
            REG_CENTER_COL:  prdata = APB_DW'(center_col_reg);
            REG_CENTER_ROW:  prdata = APB_DW'(center_row_reg);
            REG_DISC_RADIUS: prdata = APB_DW'(disc_radius_reg);
            REG_INNER_COLOR: prdata = APB_DW'(inner_color_reg);
            REG_OUTER_COLOR: prdata = APB_DW'(outer_color_reg);
            REG_EDGE_WIDTH:  prdata = APB_DW'(edge_width_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Values derived from the configuration, refreshed every cycle.
    // ------------------------------------------------------------------
    logic [HI_W-1:0]     hi;
    logic signed [LO_W-1:0] lo;
    logic [2*HI_W-1:0]   hisq_reg;
    logic [2*HI_W-1:0]   losq_reg;
    logic                lo_pos_reg;
    logic signed [LO_W-1:0] lo_reg;
    logic                fits_reg;
    logic [FITW-1:0]     col_sum;
    logic [FITW-1:0]     row_sum;
    logic [DVS_W-1:0]    dvs;

    assign hi  = {1'b0, disc_radius_reg, 1'b0} + HI_W'(edge_width_reg);
    assign lo  = $signed({2'b00, disc_radius_reg, 1'b0}) - $signed(LO_W'(edge_width_reg));
    assign col_sum = FITW'(center_col_reg) + FITW'(disc_radius_reg);
    assign row_sum = FITW'(center_row_reg) + FITW'(disc_radius_reg);
    assign dvs = {edge_width_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        hisq_reg   <= hi * hi;
        losq_reg   <= lo[HI_W-1:0] * lo[HI_W-1:0];
        lo_pos_reg <= (lo > 0);
        lo_reg     <= lo;
        fits_reg   <= !((center_col_reg < disc_radius_reg) ||
                        (center_row_reg < disc_radius_reg) ||
                        (col_sum > (FITW'(image_cols_reg) << FRAC_BITS)) ||
                        (row_sum > (FITW'(image_rows_reg) << FRAC_BITS)));
    end

    // ------------------------------------------------------------------
    // Pipeline; every stage advances together.
    // ------------------------------------------------------------------
    logic en;
    logic out_vld_reg;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // Stage 1: coordinate differences.
    logic            v1_reg;
    logic [DW-1:0]   dx_reg;
    logic [DW-1:0]   dy_reg;
    logic [DW-1:0]   px;
    logic [DW-1:0]   py;
    logic [DW-1:0]   cx;
    logic [DW-1:0]   cy;

    assign px = DW'(s_tdata[COORD_BITS-1:0]) << FRAC_BITS;
    assign py = DW'(s_tdata[2*COORD_BITS-1:COORD_BITS]) << FRAC_BITS;
    assign cx = DW'(center_col_reg);
    assign cy = DW'(center_row_reg);

    // Stage 2: squares.  Stage 3: squared distance.
    logic              v2_reg;
    logic [2*DW-1:0]   sqx_reg;
    logic [2*DW-1:0]   sqy_reg;
    logic              v3_reg;
    logic [D2W-1:0]    d2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= (px >= cx) ? (px - cx) : (cx - px);
            dy_reg  <= (py >= cy) ? (py - cy) : (cy - py);
            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
            d2_reg  <= D2W'(sqx_reg) + D2W'(sqy_reg);
        end
    end

    // Region decision on exact squared distances, then the square root.
    logic [CW-1:0]  d2x4;
    region_t        region_in;
    logic           sq_vld;
    logic [SQW-1:0] q;
    logic [1:0]     sq_sb;
    logic [XW-1:0]  sq_x;

    assign d2x4 = CW'(d2_reg) << 2;
    assign sq_x = XW'(d2_reg) << 16;

    always_comb
    begin
        priority if (d2x4 > CW'(hisq_reg))
            region_in = REGION_OUTER;
        else if (lo_pos_reg && (d2x4 < CW'(losq_reg)))
            region_in = REGION_INNER;
        else
            region_in = REGION_EDGE;
    end

    adpg_sqrt #(
        .SQW (SQW),
        .SBW (2)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v3_reg),
        .in_x     (sq_x),
        .in_sb    (region_in),
        .out_vld  (sq_vld),
        .out_root (q),
        .out_sb   (sq_sb)
    );

    // Blend numerator and its range checks.
    logic signed [FW-1:0] diff;
    logic [NW-1:0]        num;
    logic                 v4_reg;
    logic [NUMW-1:0]      num_reg;
    blend_ctl_t           ctl_reg;

    assign diff = $signed(FW'(q)) - ($signed(FW'(lo_reg)) <<< 7);
    assign num  = (NW'(diff) << 9) + NW'(edge_width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg        <= num[NUMW-1:0];
            ctl_reg.region <= region_t'(sq_sb);
            ctl_reg.zero_w <= (diff <= 0) || (edge_width_reg == '0);
            ctl_reg.full_w <= (num >= (NW'(dvs) << QB));
        end
    end

    logic          dv_vld;
    logic [QB-1:0] quot;
    blend_ctl_t    dv_ctl;

    adpg_div #(
        .QB  (QB),
        .DVW (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v4_reg),
        .in_num   (num_reg),
        .dvs      (dvs),
        .in_ctl   (ctl_reg),
        .out_vld  (dv_vld),
        .out_quot (quot),
        .out_ctl  (dv_ctl)
    );

    // Weight products, then the rounded sum into the output register.
    logic [WEIGHT_W-1:0]          wa;
    logic                         v5_reg;
    logic [COLOR_W+WEIGHT_W-1:0]  pin_reg;
    logic [COLOR_W+WEIGHT_W-1:0]  pout_reg;
    region_t                      region5_reg;
    logic [COLOR_W+WEIGHT_W:0]    blend_sum;
    logic [COLOR_W-1:0]           value;

    always_comb
    begin
        priority if (dv_ctl.zero_w)
            wa = '0;
        else if (dv_ctl.full_w)
            wa = WEIGHT_W'(65536);
        else
            wa = WEIGHT_W'(quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg      <= dv_vld;
            out_vld_reg <= v5_reg;
        end
    end

    assign blend_sum = (COLOR_W+WEIGHT_W+1)'(pin_reg) + (COLOR_W+WEIGHT_W+1)'(pout_reg)
                       + (COLOR_W+WEIGHT_W+1)'(32768);

    always_comb
    begin
        unique case (region5_reg)
            REGION_INNER: value = inner_color_reg;
            REGION_OUTER: value = outer_color_reg;
            default:      value = blend_sum[COLOR_W+15:16];
        endcase
    end

    logic [COLOR_W-1:0] value_reg;
    logic [1:0]         region_reg;
    logic               fits_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pin_reg      <= inner_color_reg * (WEIGHT_W'(65536) - wa);
            pout_reg     <= outer_color_reg * wa;
            region5_reg  <= dv_ctl.region;
            value_reg    <= fits_reg ? value : '0;
            region_reg   <= fits_reg ? 2'(region5_reg) : 2'(REGION_INNER);
            fits_out_reg <= fits_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = {fits_out_reg, region_reg};

endmodule
